/* rtl/mjsl_pkg.sv */
// Shared constants, item codes and control interface types for the multi-joint slew limiter.
package mjsl_pkg;

  localparam int KIND_W = 2;
  localparam int ROW_W  = 5;
  localparam int ANG_W  = 16;
  localparam int STEP_W = 16;

  localparam int NUM_JOINTS_DEF = 25;
  localparam logic [STEP_W-1:0] MAX_STEP_RST = 16'd360;

  // Stream word layouts.
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = KIND_W;
  localparam int M_TDATA_W = 48;

  // Item kinds; the fourth code is unused and yields an all-zero result.
  localparam logic [KIND_W-1:0] KIND_SET  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  typedef struct packed {
    logic load_item;
    logic step_walk;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic new_tick;
    logic walk_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

/* rtl/mjsl_ctrl.sv */
// Controller state machine that sequences item intake, the joint walk and result hand-off.
module mjsl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  output logic                  s_ready,
  input  mjsl_pkg::ctrl_sts_t   sts,
  output mjsl_pkg::ctrl_cmd_t   cmd
);
  import mjsl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_ready    = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_valid) begin
          cmd.load_item = 1'b1;
          state_next    = sts.new_tick ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        cmd.step_walk = 1'b1;
        if (sts.walk_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_ready) |=> (state != ST_IDLE))
    else $error("accepted transfer did not start processing");

  a_walk_ends_in_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && sts.walk_last) |=> (state == ST_DONE))
    else $error("joint walk did not end in the result state");

  a_finish_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == ST_IDLE))
    else $error("result hand-off did not return to idle");

endmodule

/* rtl/mjsl_datapath.sv */
// Datapath: item latch, angle stores, per-joint slew step, changed-row tracking and output register.
module mjsl_datapath #(
  parameter int NUM_JOINTS = mjsl_pkg::NUM_JOINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [mjsl_pkg::KIND_W-1:0]        in_kind,
  input  logic [mjsl_pkg::ROW_W-1:0]         in_row,
  input  logic signed [mjsl_pkg::ANG_W-1:0]  in_angle,
  input  logic                               cfg_we,
  input  logic [mjsl_pkg::STEP_W-1:0]        cfg_wdata,
  input  mjsl_pkg::ctrl_cmd_t                cmd,
  output mjsl_pkg::ctrl_sts_t                sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_accepted,
  output logic                               out_changed,
  output logic [mjsl_pkg::ROW_W-1:0]         out_first_row,
  output logic [mjsl_pkg::ROW_W-1:0]         out_last_row,
  output logic signed [mjsl_pkg::ANG_W-1:0]  out_cmd_angle,
  output logic signed [mjsl_pkg::ANG_W-1:0]  out_cur_angle
);
  import mjsl_pkg::*;

  localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int WIDE_W = ANG_W + 2;

  logic [KIND_W-1:0]        kind_q;
  logic [ROW_W-1:0]         row_q;
  logic signed [ANG_W-1:0]  angle_q;
  logic [STEP_W-1:0]        max_step;
  logic [IDX_W-1:0]         cnt;
  logic                     any_chg;
  logic [ROW_W-1:0]         lo_row;
  logic [ROW_W-1:0]         hi_row;

  logic signed [ANG_W-1:0]  command_store [NUM_JOINTS];
  logic signed [ANG_W-1:0]  current_store [NUM_JOINTS];

  logic                     row_ok;
  logic [IDX_W-1:0]         rd_idx;
  logic signed [ANG_W-1:0]  rd_cmd;
  logic signed [ANG_W-1:0]  rd_cur;
  logic signed [WIDE_W-1:0] delta;
  logic signed [WIDE_W-1:0] lim_s;
  logic signed [WIDE_W-1:0] cur_w;
  logic signed [WIDE_W-1:0] moved_w;
  logic signed [ANG_W-1:0]  new_cur;
  logic                     joint_diff;

  assign row_ok = ({1'b0, row_q} < (ROW_W + 1)'(NUM_JOINTS));

  // One read address serves both the walk and a row read.
  assign rd_idx = cmd.step_walk ? cnt : row_q[IDX_W-1:0];
  assign rd_cmd = command_store[rd_idx];
  assign rd_cur = current_store[rd_idx];

  assign cur_w      = {{2{rd_cur[ANG_W-1]}}, rd_cur};
  assign delta      = {{2{rd_cmd[ANG_W-1]}}, rd_cmd} - cur_w;
  assign lim_s      = WIDE_W'(max_step);
  assign joint_diff = (delta != '0);

  // A step never passes the command, so the moved value fits the angle width.
  always_comb begin
    moved_w = cur_w;
    if (delta < -lim_s) begin
      moved_w = cur_w - lim_s;
    end else if (delta > lim_s) begin
      moved_w = cur_w + lim_s;
    end
    new_cur = ((delta < -lim_s) || (delta > lim_s)) ? moved_w[ANG_W-1:0] : rd_cmd;
  end

  assign sts.new_tick  = (in_kind == KIND_TICK);
  assign sts.walk_last = (cnt == IDX_W'(NUM_JOINTS - 1));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_step <= MAX_STEP_RST;
    end else if (cfg_we) begin
      max_step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_q  <= in_kind;
      row_q   <= in_row;
      angle_q <= in_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      any_chg <= 1'b0;
      lo_row  <= '0;
      hi_row  <= '0;
    end else if (cmd.load_item) begin
      cnt     <= '0;
      any_chg <= 1'b0;
      lo_row  <= '0;
      hi_row  <= '0;
    end else if (cmd.step_walk) begin
      cnt <= cnt + 1'b1;
      if (joint_diff) begin
        if (!any_chg) begin
          lo_row <= ROW_W'(cnt);
        end
        hi_row  <= ROW_W'(cnt);
        any_chg <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        command_store[i] <= '0;
        current_store[i] <= '0;
      end
    end else begin
      if (cmd.step_walk) begin
        current_store[cnt] <= new_cur;
      end
      if (cmd.finish && kind_q == KIND_SET && row_ok) begin
        command_store[row_q[IDX_W-1:0]] <= angle_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_accepted  <= 1'b0;
      out_changed   <= 1'b0;
      out_first_row <= '0;
      out_last_row  <= '0;
      out_cmd_angle <= '0;
      out_cur_angle <= '0;
      if (kind_q == KIND_SET) begin
        if (row_ok) begin
          out_accepted  <= 1'b1;
          out_changed   <= 1'b1;
          out_first_row <= row_q;
          out_last_row  <= row_q;
        end
      end else if (kind_q == KIND_TICK) begin
        out_accepted  <= 1'b1;
        out_changed   <= any_chg;
        out_first_row <= lo_row;
        out_last_row  <= hi_row;
      end else if (kind_q == KIND_READ) begin
        if (row_ok) begin
          out_accepted  <= 1'b1;
          out_cmd_angle <= rd_cmd;
          out_cur_angle <= rd_cur;
        end
      end
    end
  end

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result loaded over an unread result");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step_walk |-> (cnt <= IDX_W'(NUM_JOINTS - 1)))
    else $error("joint walk index past the last joint");

  a_rows_ordered: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && kind_q == KIND_TICK && any_chg) |-> (lo_row <= hi_row))
    else $error("lowest changed row above highest changed row");

endmodule

/* rtl/multi_joint_slew_limiter_top.sv */
// Top level of the multi-joint slew limiter: stream ports, controller and datapath.
// Each joint row keeps a command angle and a current angle (signed hundredths of a degree).
// A set or read item passes from its transfer through the accept cycle and the result stage
// before the next item's transfer; a tick also walks the joints one per cycle, between those
// two, through the single read-modify-write path of the angle registers. A result waits in
// an output register while the next item is taken in; the block holds a finished result back
// only while that register is still full.
// Configuration writes to max_step take effect at the next clock edge.
module multi_joint_slew_limiter_top #(
  parameter int NUM_JOINTS = mjsl_pkg::NUM_JOINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // row [4:0], angle [20:5], zero [23:21]
  input  logic [mjsl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // kind [1:0]
  input  logic [mjsl_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // accepted [0], changed [1], first_row [6:2], last_row [11:7],
  // cmd_angle [27:12], cur_angle [43:28], zero [47:44]
  output logic [mjsl_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [mjsl_pkg::STEP_W-1:0]       cfg_wdata
);
  import mjsl_pkg::*;

  ctrl_cmd_t               cmd;
  ctrl_sts_t               sts;
  logic                    out_accepted;
  logic                    out_changed;
  logic [ROW_W-1:0]        out_first_row;
  logic [ROW_W-1:0]        out_last_row;
  logic signed [ANG_W-1:0] out_cmd_angle;
  logic signed [ANG_W-1:0] out_cur_angle;

  mjsl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  mjsl_datapath #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .in_kind       (s_axis_tuser[KIND_W-1:0]),
    .in_row        (s_axis_tdata[ROW_W-1:0]),
    .in_angle      (s_axis_tdata[ROW_W+ANG_W-1:ROW_W]),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_accepted  (out_accepted),
    .out_changed   (out_changed),
    .out_first_row (out_first_row),
    .out_last_row  (out_last_row),
    .out_cmd_angle (out_cmd_angle),
    .out_cur_angle (out_cur_angle)
  );

  assign m_axis_tdata = {4'b0000, out_cur_angle, out_cmd_angle, out_last_row,
                         out_first_row, out_changed, out_accepted};

endmodule
